>>> hw/rtl/shtm_pkg.sv
// Shared types and constants for the two-wire humidity sensor master.
// Used by shtm_seq and two_wire_humidity_sensor_master_top; no dependencies.
package shtm_pkg;

    // Configuration reset values
    localparam logic [7:0]  CLK_HIGH_RST = 8'd5;
    localparam logic [31:0] TIMEOUT_RST  = 32'd4294836225;

    // Register indexes on the configuration port (paddr[2])
    localparam logic REG_CLK_HIGH = 1'b0;
    localparam logic REG_TIMEOUT  = 1'b1;

    // Action codes
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_HUMIDITY = 2'd1;
    localparam logic [1:0] ACT_TEMP     = 2'd2;
    localparam logic [1:0] ACT_CONN_RST = 2'd3;

    // Sensor commands
    localparam logic [7:0] CMD_HUMIDITY = 8'h05;
    localparam logic [7:0] CMD_TEMP     = 8'h03;

    // Sequence phases
    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_RST_HI   = 5'd1;
    localparam logic [4:0] PH_RST_LO   = 5'd2;
    localparam logic [4:0] PH_TS_A     = 5'd3;
    localparam logic [4:0] PH_TS_B     = 5'd4;
    localparam logic [4:0] PH_TS_C     = 5'd5;
    localparam logic [4:0] PH_TS_D     = 5'd6;
    localparam logic [4:0] PH_TS_E     = 5'd7;
    localparam logic [4:0] PH_TS_F     = 5'd8;
    localparam logic [4:0] PH_TS_G     = 5'd9;
    localparam logic [4:0] PH_WR_HI    = 5'd10;
    localparam logic [4:0] PH_WR_LO    = 5'd11;
    localparam logic [4:0] PH_ACK_NOP  = 5'd12;
    localparam logic [4:0] PH_ACK_HOLD = 5'd13;
    localparam logic [4:0] PH_WAIT     = 5'd14;
    localparam logic [4:0] PH_RD_HI    = 5'd15;
    localparam logic [4:0] PH_RD_LO    = 5'd16;
    localparam logic [4:0] PH_RD_ACK   = 5'd17;

    localparam int RESULT_W = 32;

    typedef struct packed {
        logic [7:0]  clk_high;
        logic [31:0] timeout;
    } t_cfg;

    // Packed so that the last field lands in the lowest bit
    typedef struct packed {
        logic [1:0]  pad;
        logic [1:0]  error_count;
        logic [7:0]  checksum_byte;
        logic [15:0] measured_value;
        logic        done_res;
        logic        busy_res;
        logic        data_released;
        logic        clock_line;
    } t_result;

endpackage

>>> hw/rtl/shtm_seq.sv
// Bus sequencer: phase state, tick counter and read shifter, one tick per step.
// Depends on shtm_pkg.
module shtm_seq
    import shtm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [1:0] i_action,
    input  logic       i_din,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic [4:0]  r_phase, n_phase;
    logic [31:0] r_tick,  n_tick;
    logic [3:0]  r_bit,   n_bit;
    logic [1:0]  r_byte,  n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [23:0] r_recv,  n_recv;
    logic [1:0]  r_err,   n_err;

    logic [31:0] long_len;
    logic [31:0] wait_len;
    logic [31:0] ph_len;
    logic [4:0]  cur;
    logic        ends;
    logic        clk_lv;
    logic        dat_lv;
    logic        busy;
    logic        done;

    assign long_len = (i_cfg.clk_high == 8'd0) ? 32'd1 : {24'd0, i_cfg.clk_high};
    assign wait_len = (i_cfg.timeout == 32'd0) ? 32'd1 : i_cfg.timeout;

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_recv  = r_recv;
        n_err   = r_err;
        clk_lv  = 1'b0;
        dat_lv  = 1'b1;
        busy    = 1'b0;
        done    = 1'b0;
        ends    = 1'b0;
        ph_len  = 32'd2;

        // Launch a new sequence from idle
        if (r_phase == PH_IDLE && i_action != ACT_NONE) begin
            n_bit  = 4'd0;
            n_byte = 2'd0;
            n_tick = 32'd0;
            if (i_action == ACT_CONN_RST) begin
                n_shift = 8'd0;
                n_phase = PH_RST_HI;
            end else begin
                n_shift = (i_action == ACT_HUMIDITY) ? CMD_HUMIDITY : CMD_TEMP;
                n_err   = 2'd0;
                n_phase = PH_TS_A;
            end
        end

        cur = n_phase;

        if (cur != PH_IDLE) begin
            busy = 1'b1;

            unique case (cur)
                PH_TS_D, PH_WR_HI, PH_RD_LO, PH_RD_ACK: ph_len = long_len;
                PH_WR_LO, PH_ACK_NOP, PH_RD_HI:         ph_len = 32'd1;
                PH_ACK_HOLD:                            ph_len = 32'd3;
                PH_WAIT:                                ph_len = wait_len;
                default:                                ph_len = 32'd2;
            endcase
            ends = ({1'b0, n_tick} + 33'd1) >= {1'b0, ph_len};

            unique case (cur)
                PH_RST_HI, PH_TS_B, PH_TS_F, PH_ACK_NOP, PH_ACK_HOLD, PH_RD_HI: begin
                    clk_lv = 1'b1;
                end
                PH_TS_C, PH_TS_E: begin
                    clk_lv = 1'b1;
                    dat_lv = 1'b0;
                end
                PH_TS_D: dat_lv = 1'b0;
                PH_WR_HI, PH_WR_LO: begin
                    clk_lv = (cur == PH_WR_HI);
                    dat_lv = n_shift[3'd7 - n_bit[2:0]];
                end
                PH_RD_ACK: begin
                    clk_lv = 1'b1;
                    dat_lv = (n_byte >= 2'd2);
                end
                default: ;
            endcase

            // Acknowledge sampled on the first hold tick
            if (cur == PH_ACK_HOLD && n_tick == 32'd0 && i_din && n_err != 2'd3)
                n_err = n_err + 2'd1;
            if (cur == PH_RD_HI)
                n_shift = {n_shift[6:0], i_din};
            if (cur == PH_WAIT) begin
                if (!i_din)
                    ends = 1'b1;
                else if (ends && n_err != 2'd3)
                    n_err = n_err + 2'd1;
            end

            if (!ends) begin
                n_tick = n_tick + 32'd1;
            end else begin
                n_tick = 32'd0;
                unique case (cur)
                    PH_RST_HI: n_phase = PH_RST_LO;
                    PH_RST_LO: begin
                        n_bit = n_bit + 4'd1;
                        if (n_bit >= 4'd9) begin
                            n_bit   = 4'd0;
                            n_phase = PH_TS_A;
                        end else begin
                            n_phase = PH_RST_HI;
                        end
                    end
                    PH_TS_A: n_phase = PH_TS_B;
                    PH_TS_B: n_phase = PH_TS_C;
                    PH_TS_C: n_phase = PH_TS_D;
                    PH_TS_D: n_phase = PH_TS_E;
                    PH_TS_E: n_phase = PH_TS_F;
                    PH_TS_F: n_phase = PH_TS_G;
                    PH_TS_G: begin
                        n_bit   = 4'd0;
                        // connection reset carries no command
                        n_phase = (n_shift == 8'd0) ? PH_IDLE : PH_WR_HI;
                    end
                    PH_WR_HI: n_phase = PH_WR_LO;
                    PH_WR_LO: begin
                        n_bit = n_bit + 4'd1;
                        if (n_bit >= 4'd8) begin
                            n_bit   = 4'd0;
                            n_phase = PH_ACK_NOP;
                        end else begin
                            n_phase = PH_WR_HI;
                        end
                    end
                    PH_ACK_NOP:  n_phase = PH_ACK_HOLD;
                    PH_ACK_HOLD: n_phase = PH_WAIT;
                    PH_WAIT: begin
                        n_bit   = 4'd0;
                        n_byte  = 2'd0;
                        n_shift = 8'd0;
                        n_phase = PH_RD_HI;
                    end
                    PH_RD_HI: n_phase = PH_RD_LO;
                    PH_RD_LO: begin
                        n_bit = n_bit + 4'd1;
                        if (n_bit >= 4'd8) begin
                            n_bit   = 4'd0;
                            n_phase = PH_RD_ACK;
                        end else begin
                            n_phase = PH_RD_HI;
                        end
                    end
                    PH_RD_ACK: begin
                        n_recv  = {n_recv[15:0], n_shift};
                        n_shift = 8'd0;
                        n_byte  = n_byte + 2'd1;
                        if (n_byte >= 2'd3) begin
                            n_byte  = 2'd0;
                            done    = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_RD_HI;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end

        o_result.pad            = 2'd0;
        o_result.error_count    = n_err;
        o_result.checksum_byte  = n_recv[7:0];
        o_result.measured_value = n_recv[23:8];
        o_result.done_res       = done;
        o_result.busy_res       = busy;
        o_result.data_released  = dat_lv;
        o_result.clock_line     = clk_lv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= 32'd0;
            r_bit   <= 4'd0;
            r_byte  <= 2'd0;
            r_shift <= 8'd0;
            r_recv  <= 24'd0;
            r_err   <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_recv  <= n_recv;
            r_err   <= n_err;
        end
    end

endmodule

>>> hw/rtl/two_wire_humidity_sensor_master_top.sv
// Top level of the two-wire sensor master; depends on shtm_pkg and shtm_seq.
// A tick's result is registered when its beat is taken, into the skid entry if stalled.
// Throughput: one tick per cycle while tready is high, set by the single-pass sequencer
// logic; a skid stage keeps input flowing for one beat while the output is stalled.
// Reset (synchronous, active low): sequencer idle, counters and read data zero,
// configuration back to its reset values (CLK_HIGH_RST, TIMEOUT_RST), no result held.
module two_wire_humidity_sensor_master_top
    import shtm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: [1:0] action, [2] data_line_in, [7:3] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // tdata: [0] clock_line, [1] data_released, [2] busy_res, [3] done_res,
    //        [19:4] measured_value, [27:20] checksum_byte, [29:28] error_count, [31:30] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [RESULT_W-1:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  r_clk_high;
    logic [31:0] r_timeout;
    t_cfg        cfg;
    logic        cfg_wr;

    logic        r_out_valid;
    t_result     r_out_data;
    logic        r_skid_valid;
    t_result     r_skid_data;
    t_result     step_res;
    logic        in_acc;
    logic        out_take;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_high <= CLK_HIGH_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CLK_HIGH: r_clk_high <= pwdata[7:0];
                REG_TIMEOUT:  r_timeout  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CLK_HIGH: prdata = {24'd0, r_clk_high};
            REG_TIMEOUT:  prdata = r_timeout;
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.clk_high = r_clk_high;
    assign cfg.timeout  = r_timeout;

    assign s_axis_tready = ~r_skid_valid;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_take      = r_out_valid & m_axis_tready;

    shtm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_acc),
        .i_action (s_axis_tdata[1:0]),
        .i_din    (s_axis_tdata[2]),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            if (r_out_valid)
                r_skid_valid <= 1'b1;
            else
                r_out_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            if (r_skid_valid)
                r_out_data <= r_skid_data;
            else if (in_acc)
                r_out_data <= step_res;
        end else if (in_acc) begin
            if (r_out_valid)
                r_skid_data <= step_res;
            else
                r_out_data <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
